>>> rtl/cvb_pkg.sv
// Shared types, constants and arithmetic helpers for the camera view basis block.
package cvb_pkg;

	localparam int POS_W  = 32;
	localparam int AXIS_W = 20;
	localparam int Q30_W  = 32;
	localparam int WIDE_W = 64;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef logic signed [Q30_W-1:0]  q30_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [15:0]       angle_t;
	typedef logic [2:0]               func_t;

	localparam func_t FN_LOOK  = 3'd0;
	localparam func_t FN_ROLL  = 3'd1;
	localparam func_t FN_YAW   = 3'd2;
	localparam func_t FN_PITCH = 3'd3;
	localparam func_t FN_SLIDE = 3'd4;

	localparam logic [1:0] AX_RIGHT = 2'd0;
	localparam logic [1:0] AX_UP    = 2'd1;
	localparam logic [1:0] AX_BACK  = 2'd2;

	localparam int   QUARTER_UNITS = 5760;
	localparam int   ANGLE_BIAS    = 8 * QUARTER_UNITS;
	localparam int   CORDIC_STEPS  = 22;
	localparam q30_t CORDIC_GAIN   = 32'sd652032874;
	localparam q30_t ONE_Q30       = 32'sd1073741824;
	localparam axis_t AXIS_ONE     = axis_t'(65536);

	localparam wide_t AXIS_MAX = (64'sd1 <<< (AXIS_W - 1)) - 64'sd1;
	localparam wide_t AXIS_MIN = -AXIS_MAX - 64'sd1;
	localparam wide_t POS_MAX  = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
	localparam wide_t POS_MIN  = -POS_MAX - 64'sd1;

	function automatic q30_t atan_deg(input logic [4:0] idx);
		case (idx)
			5'd0:    return 32'sd2949120;
			5'd1:    return 32'sd1740967;
			5'd2:    return 32'sd919879;
			5'd3:    return 32'sd466945;
			5'd4:    return 32'sd234379;
			5'd5:    return 32'sd117304;
			5'd6:    return 32'sd58666;
			5'd7:    return 32'sd29335;
			5'd8:    return 32'sd14668;
			5'd9:    return 32'sd7334;
			5'd10:   return 32'sd3667;
			5'd11:   return 32'sd1833;
			5'd12:   return 32'sd917;
			5'd13:   return 32'sd458;
			5'd14:   return 32'sd229;
			5'd15:   return 32'sd115;
			5'd16:   return 32'sd57;
			5'd17:   return 32'sd29;
			5'd18:   return 32'sd14;
			5'd19:   return 32'sd7;
			5'd20:   return 32'sd4;
			5'd21:   return 32'sd2;
			default: return 32'sd0;
		endcase
	endfunction

	function automatic q30_t clamp_unit(input q30_t v);
		if (v > ONE_Q30)
			return ONE_Q30;
		if (v < -ONE_Q30)
			return -ONE_Q30;
		return v;
	endfunction

	function automatic axis_t sat_axis(input wide_t v);
		if (v > AXIS_MAX)
			return AXIS_MAX[AXIS_W-1:0];
		if (v < AXIS_MIN)
			return AXIS_MIN[AXIS_W-1:0];
		return v[AXIS_W-1:0];
	endfunction

	function automatic pos_t sat_pos(input wide_t v);
		if (v > POS_MAX)
			return POS_MAX[POS_W-1:0];
		if (v < POS_MIN)
			return POS_MIN[POS_W-1:0];
		return v[POS_W-1:0];
	endfunction

	function automatic wide_t rnd16(input wide_t v);
		return (v + (64'sd1 <<< 15)) >>> 16;
	endfunction

	function automatic wide_t rnd30(input wide_t v);
		return (v + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic axis_t q30_to_axis(input q30_t q);
		wide_t w;
		w = WIDE_W'(q);
		return sat_axis((w + (64'sd1 <<< 13)) >>> 14);
	endfunction

	function automatic logic [1:0] nxt1(input logic [1:0] i);
		case (i)
			2'd0:    return 2'd1;
			2'd1:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] nxt2(input logic [1:0] i);
		case (i)
			2'd0:    return 2'd2;
			2'd1:    return 2'd0;
			default: return 2'd1;
		endcase
	endfunction

endpackage

>>> rtl/camera_view_basis_update.sv
// Camera view basis: eye and axes state, command sequencer and view-row output.
// One request is taken at a time; req_stall stays high until its three rows are
// delivered. All products of the sequencer go through a single registered 32x32
// multiplier; the normalizer squares components on a small multiplier of its own.
// Roll, yaw and pitch run up to 13 wrap steps and 22 CORDIC steps, then 12
// products before the rows; look-at is set by four passes of the normalizer (up
// to 32 scaling shifts, 32 square-root steps and three 31-step divisions each).
// Each row is held on the outputs for as long as row_stall is high.
module camera_view_basis_update (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  cvb_pkg::func_t    func,
	input  cvb_pkg::pos_t     vec_a_x,
	input  cvb_pkg::pos_t     vec_a_y,
	input  cvb_pkg::pos_t     vec_a_z,
	input  cvb_pkg::pos_t     look_target_x,
	input  cvb_pkg::pos_t     look_target_y,
	input  cvb_pkg::pos_t     look_target_z,
	input  cvb_pkg::pos_t     up_hint_x,
	input  cvb_pkg::pos_t     up_hint_y,
	input  cvb_pkg::pos_t     up_hint_z,
	input  cvb_pkg::angle_t   turn_angle,
	output logic              row_valid,
	input  logic              row_stall,
	output logic [1:0]        row_index,
	output cvb_pkg::axis_t    row_axis_x,
	output cvb_pkg::axis_t    row_axis_y,
	output cvb_pkg::axis_t    row_axis_z,
	output cvb_pkg::pos_t     row_offset,
	output logic              last_row
);
	import cvb_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_TRIG  = 4'd1;
	localparam logic [3:0] ST_ROT   = 4'd2;
	localparam logic [3:0] ST_SLIDE = 4'd3;
	localparam logic [3:0] ST_NWAIT = 4'd4;
	localparam logic [3:0] ST_CROSS = 4'd5;
	localparam logic [3:0] ST_ROW   = 4'd6;
	localparam logic [3:0] ST_OUT   = 4'd7;

	logic [3:0] st_q;
	func_t      func_q;
	pos_t       va_q [3];
	pos_t       up_q [3];
	angle_t     angle_q;
	axis_t      axis_q [3][3];
	pos_t       eye_q [3];
	q30_t       v_q [3][3];
	wide_t      nin_q [3];
	wide_t      acc_q, na_q;
	logic [1:0] i_q, t_q, k_q, la_q;
	logic       ph_q;
	logic       nstart_q, cstart_q;
	logic       row_valid_q, last_q;
	logic [1:0] row_index_q;
	axis_t      row_ax_q [3];
	pos_t       row_off_q;

	logic       cdone, ndone;
	q30_t       cs_cos, cs_sin;
	q30_t       nout [3];
	pos_t       op_a, op_b;
	wide_t      prod, base, sum_nx;
	logic [1:0] pa, pb;
	logic       req_acc;

	assign req_stall = (st_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;

	cvb_mul u_mul (
		.clk  (clk),
		.a    (op_a),
		.b    (op_b),
		.prod (prod)
	);

	cvb_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cstart_q),
		.angle  (angle_q),
		.done   (cdone),
		.cos_v  (cs_cos),
		.sin_v  (cs_sin)
	);

	cvb_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (nstart_q),
		.vec_in  (nin_q),
		.done    (ndone),
		.vec_out (nout)
	);

	always_comb begin
		unique case (func_q)
			FN_ROLL: begin pa = AX_RIGHT; pb = AX_UP;    end
			FN_YAW:  begin pa = AX_BACK;  pb = AX_RIGHT; end
			default: begin pa = AX_UP;    pb = AX_BACK;  end
		endcase
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (st_q)
			ST_ROT: begin
				case (t_q)
					2'd0: begin op_a = cs_cos; op_b = POS_W'(axis_q[pa][i_q]); end
					2'd1: begin op_a = cs_sin; op_b = POS_W'(axis_q[pb][i_q]); end
					2'd2: begin op_a = cs_sin; op_b = POS_W'(axis_q[pa][i_q]); end
					default: begin op_a = cs_cos; op_b = POS_W'(axis_q[pb][i_q]); end
				endcase
			end
			ST_SLIDE: begin
				op_a = va_q[t_q];
				op_b = POS_W'(axis_q[t_q][i_q]);
			end
			ST_CROSS: begin
				if (la_q == 2'd2) begin
					op_a = t_q[0] ? v_q[1][nxt2(i_q)] : v_q[1][nxt1(i_q)];
					op_b = t_q[0] ? v_q[0][nxt1(i_q)] : v_q[0][nxt2(i_q)];
				end else begin
					op_a = t_q[0] ? v_q[0][nxt2(i_q)] : v_q[0][nxt1(i_q)];
					op_b = t_q[0] ? v_q[1][nxt1(i_q)] : v_q[1][nxt2(i_q)];
				end
			end
			ST_ROW: begin
				op_a = eye_q[i_q];
				op_b = POS_W'(axis_q[k_q][i_q]);
			end
			default: ;
		endcase
	end

	always_comb begin
		if (st_q == ST_ROW)
			base = (i_q == 2'd0) ? '0 : acc_q;
		else
			base = (t_q == 2'd0) ? WIDE_W'(eye_q[i_q]) : acc_q;
		sum_nx = base + rnd16(prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			nstart_q    <= 1'b0;
			cstart_q    <= 1'b0;
			row_valid_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				eye_q[a] <= '0;
				for (int c = 0; c < 3; c++)
					axis_q[a][c] <= (a == c) ? AXIS_ONE : '0;
			end
		end else begin
			nstart_q <= 1'b0;
			cstart_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (req_acc) begin
						func_q  <= func;
						va_q    <= '{vec_a_x, vec_a_y, vec_a_z};
						up_q    <= '{up_hint_x, up_hint_y, up_hint_z};
						angle_q <= turn_angle;
						i_q     <= '0;
						t_q     <= '0;
						k_q     <= '0;
						ph_q    <= 1'b0;
						case (func) inside
							FN_LOOK: begin
								eye_q    <= '{vec_a_x, vec_a_y, vec_a_z};
								nin_q[0] <= WIDE_W'(vec_a_x) - WIDE_W'(look_target_x);
								nin_q[1] <= WIDE_W'(vec_a_y) - WIDE_W'(look_target_y);
								nin_q[2] <= WIDE_W'(vec_a_z) - WIDE_W'(look_target_z);
								nstart_q <= 1'b1;
								la_q     <= 2'd0;
								st_q     <= ST_NWAIT;
							end
							FN_ROLL, FN_YAW, FN_PITCH: begin
								cstart_q <= 1'b1;
								st_q     <= ST_TRIG;
							end
							FN_SLIDE: st_q <= ST_SLIDE;
							default: ;
						endcase
					end
				end
				ST_TRIG: begin
					if (cdone)
						st_q <= ST_ROT;
				end
				ST_ROT: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						case (t_q)
							2'd0: acc_q <= prod;
							2'd1: na_q  <= acc_q - prod;
							2'd2: acc_q <= prod;
							default: begin
								axis_q[pa][i_q] <= sat_axis(rnd30(na_q));
								axis_q[pb][i_q] <= sat_axis(rnd30(acc_q + prod));
							end
						endcase
						t_q <= t_q + 2'd1;
						if (t_q == 2'd3) begin
							i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
							if (i_q == 2'd2)
								st_q <= ST_ROW;
						end
					end
				end
				ST_SLIDE: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						acc_q <= sum_nx;
						if (t_q == 2'd2) begin
							eye_q[i_q] <= sat_pos(sum_nx);
							t_q        <= '0;
							i_q        <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
							if (i_q == 2'd2)
								st_q <= ST_ROW;
						end else
							t_q <= t_q + 2'd1;
					end
				end
				ST_CROSS: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (t_q == 2'd0) begin
							nin_q[i_q] <= prod;
							t_q        <= 2'd1;
						end else begin
							nin_q[i_q] <= nin_q[i_q] - prod;
							t_q        <= '0;
							if (i_q == 2'd2) begin
								i_q      <= '0;
								nstart_q <= 1'b1;
								st_q     <= ST_NWAIT;
							end else
								i_q <= i_q + 2'd1;
						end
					end
				end
				ST_NWAIT: begin
					if (ndone) begin
						case (la_q)
							2'd0: begin
								v_q[0]   <= nout;
								nin_q[0] <= WIDE_W'(up_q[0]);
								nin_q[1] <= WIDE_W'(up_q[1]);
								nin_q[2] <= WIDE_W'(up_q[2]);
								nstart_q <= 1'b1;
								la_q     <= 2'd1;
							end
							2'd1, 2'd2: begin
								v_q[1] <= nout;
								la_q   <= la_q + 2'd1;
								i_q    <= '0;
								t_q    <= '0;
								ph_q   <= 1'b0;
								st_q   <= ST_CROSS;
							end
							default: begin
								v_q[2] <= nout;
								for (int c = 0; c < 3; c++) begin
									axis_q[AX_RIGHT][c] <= q30_to_axis(v_q[1][c]);
									axis_q[AX_UP][c]    <= q30_to_axis(nout[c]);
									axis_q[AX_BACK][c]  <= q30_to_axis(v_q[0][c]);
								end
								i_q  <= '0;
								ph_q <= 1'b0;
								st_q <= ST_ROW;
							end
						endcase
					end
				end
				ST_ROW: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						acc_q <= sum_nx;
						if (i_q == 2'd2) begin
							row_index_q <= k_q;
							row_ax_q    <= axis_q[k_q];
							row_off_q   <= sat_pos(-sum_nx);
							last_q      <= (k_q == 2'd2);
							row_valid_q <= 1'b1;
							i_q         <= '0;
							st_q        <= ST_OUT;
						end else
							i_q <= i_q + 2'd1;
					end
				end
				ST_OUT: begin
					if (!row_stall) begin
						row_valid_q <= 1'b0;
						if (k_q == 2'd2)
							st_q <= ST_IDLE;
						else begin
							k_q  <= k_q + 2'd1;
							st_q <= ST_ROW;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign row_valid  = row_valid_q;
	assign row_index  = row_index_q;
	assign row_axis_x = row_ax_q[0];
	assign row_axis_y = row_ax_q[1];
	assign row_axis_z = row_ax_q[2];
	assign row_offset = row_off_q;
	assign last_row   = last_q;

	a_row_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> st_q == ST_OUT)
		else $error("row shown outside output state");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && func <= FN_SLIDE |=> req_stall)
		else $error("request accepted but block not busy");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_stall && last_row |=> !row_valid && !req_stall)
		else $error("rows continue after last row");

	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		ndone |-> st_q == ST_NWAIT)
		else $error("normalizer done while not awaited");

	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cdone |-> st_q == ST_TRIG)
		else $error("cordic done while not awaited");

endmodule

>>> rtl/cvb_mul.sv
// Shared signed 32x32 multiplier with registered product.
module cvb_mul (
	input  logic          clk,
	input  cvb_pkg::pos_t a,
	input  cvb_pkg::pos_t b,
	output cvb_pkg::wide_t prod
);
	import cvb_pkg::*;

	wide_t prod_q;

	always_ff @(posedge clk) begin
		prod_q <= WIDE_W'(a) * WIDE_W'(b);
	end

	assign prod = prod_q;

endmodule

>>> rtl/cvb_cordic.sv
// Iterative sine/cosine unit: angle wrap, quadrant split and 22 CORDIC steps.
module cvb_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cvb_pkg::angle_t angle,
	output logic            done,
	output cvb_pkg::q30_t   cos_v,
	output cvb_pkg::q30_t   sin_v
);
	import cvb_pkg::*;

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_RED  = 2'd1;
	localparam logic [1:0] C_ITER = 2'd2;
	localparam logic [1:0] C_FIN  = 2'd3;

	logic [1:0]  st_q;
	logic [16:0] v_q;
	logic [1:0]  quad_q;
	q30_t        x_q, y_q, z_q;
	logic [4:0]  it_q;
	logic        done_q;
	q30_t        cos_q, sin_q;
	q30_t        dx, dy, cx, sy;

	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign cx = clamp_unit(x_q);
	assign sy = clamp_unit(y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= C_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				C_IDLE: begin
					if (start) begin
						v_q    <= {angle[15], angle} + 17'(ANGLE_BIAS);
						quad_q <= 2'd0;
						st_q   <= C_RED;
					end
				end
				C_RED: begin
					if (v_q >= 17'(QUARTER_UNITS)) begin
						v_q    <= v_q - 17'(QUARTER_UNITS);
						quad_q <= quad_q + 2'd1;
					end else begin
						z_q  <= q30_t'({15'd0, v_q}) <<< 10;
						x_q  <= CORDIC_GAIN;
						y_q  <= '0;
						it_q <= '0;
						st_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (!z_q[Q30_W-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atan_deg(it_q);
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atan_deg(it_q);
					end
					if (it_q == 5'(CORDIC_STEPS - 1))
						st_q <= C_FIN;
					else
						it_q <= it_q + 5'd1;
				end
				C_FIN: begin
					case (quad_q)
						2'd0: begin cos_q <= cx;  sin_q <= sy;  end
						2'd1: begin cos_q <= -sy; sin_q <= cx;  end
						2'd2: begin cos_q <= -cx; sin_q <= -sy; end
						default: begin cos_q <= sy; sin_q <= -cx; end
					endcase
					done_q <= 1'b1;
					st_q   <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign cos_v = cos_q;
	assign sin_v = sin_q;

endmodule

>>> rtl/cvb_norm.sv
// Vector normalizer: shift scaling, bitwise square root and restoring division.
module cvb_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cvb_pkg::wide_t vec_in [3],
	output logic           done,
	output cvb_pkg::q30_t  vec_out [3]
);
	import cvb_pkg::*;

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SCALE = 3'd1;
	localparam logic [2:0] N_SQ    = 3'd2;
	localparam logic [2:0] N_SQRT  = 3'd3;
	localparam logic [2:0] N_DSET  = 3'd4;
	localparam logic [2:0] N_DIV   = 3'd5;

	logic [2:0]  st_q;
	logic [63:0] m_q [3];
	logic        neg_q [3];
	logic [63:0] sum_q, xs_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [32:0] r_q;
	logic [30:0] nl_q, q_q;
	logic [1:0]  ci_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	q30_t        out_q [3];

	logic [63:0] orv, sum_nx, num;
	logic [59:0] sq;
	logic [34:0] rem_sh, trial;
	logic [32:0] rs;
	logic        qbit;
	logic [30:0] q_fin;

	always_comb begin
		orv    = m_q[0] | m_q[1] | m_q[2];
		sq     = m_q[ci_q][29:0] * m_q[ci_q][29:0];
		sum_nx = sum_q + {4'd0, sq};
		rem_sh = {rem_q[32:0], xs_q[63:62]};
		trial  = {1'b0, root_q, 2'b01};
		num    = (m_q[ci_q] << 30) + {33'd0, root_q[31:1]};
		rs     = {r_q[31:0], nl_q[30]};
		qbit   = rs >= {1'b0, root_q};
		q_fin  = {q_q[29:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= N_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				N_IDLE: begin
					if (start) begin
						for (int i = 0; i < 3; i++) begin
							neg_q[i] <= vec_in[i][WIDE_W-1];
							m_q[i]   <= vec_in[i][WIDE_W-1] ? 64'(-vec_in[i]) : 64'(vec_in[i]);
						end
						st_q <= N_SCALE;
					end
				end
				N_SCALE: begin
					if (orv == 64'd0) begin
						for (int i = 0; i < 3; i++)
							out_q[i] <= '0;
						done_q <= 1'b1;
						st_q   <= N_IDLE;
					end else if (|orv[63:30]) begin
						for (int i = 0; i < 3; i++)
							m_q[i] <= m_q[i] >> 1;
					end else if (~|orv[63:29]) begin
						for (int i = 0; i < 3; i++)
							m_q[i] <= m_q[i] << 1;
					end else begin
						sum_q <= '0;
						ci_q  <= '0;
						st_q  <= N_SQ;
					end
				end
				N_SQ: begin
					sum_q <= sum_nx;
					if (ci_q == 2'd2) begin
						xs_q   <= sum_nx;
						rem_q  <= '0;
						root_q <= '0;
						cnt_q  <= '0;
						st_q   <= N_SQRT;
					end else
						ci_q <= ci_q + 2'd1;
				end
				N_SQRT: begin
					xs_q <= xs_q << 2;
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						ci_q <= '0;
						st_q <= N_DSET;
					end
				end
				N_DSET: begin
					r_q   <= num[63:31];
					nl_q  <= num[30:0];
					q_q   <= '0;
					cnt_q <= '0;
					st_q  <= N_DIV;
				end
				N_DIV: begin
					r_q   <= qbit ? rs - {1'b0, root_q} : rs;
					nl_q  <= nl_q << 1;
					q_q   <= q_fin;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) begin
						out_q[ci_q] <= neg_q[ci_q] ? -q30_t'({1'b0, q_fin}) : q30_t'({1'b0, q_fin});
						if (ci_q == 2'd2) begin
							done_q <= 1'b1;
							st_q   <= N_IDLE;
						end else begin
							ci_q <= ci_q + 2'd1;
							st_q <= N_DSET;
						end
					end
				end
				default: st_q <= N_IDLE;
			endcase
		end
	end

	assign done    = done_q;
	assign vec_out = out_q;

endmodule
